// ===== src/isfp_pkg.sv =====
// Shared types, widths and the quarter-wave sine table for the phase-to-sine core.
// No dependencies; used by isfp_lookup, isfp_interp and interpolated_sine_from_phase_core.
package isfp_pkg;

	localparam int PHASE_W  = 32;
	localparam int SAMPLE_W = 16;
	localparam int IDX_W    = 8;
	localparam int FRAC_W   = 22;
	localparam int AMP_W    = 15;
	localparam int DIFF_W   = 8;
	localparam int PROD_W   = DIFF_W + FRAC_W;
	localparam int TAB_IX_W = IDX_W + 1;
	localparam int TABLE_DEPTH = 257;

	localparam logic [FRAC_W-1:0] FRAC_MAX = 22'h3fffff;
	localparam logic [IDX_W-1:0]  IDX_MAX  = 8'hff;

	// Lookup result handed from the table stage to the interpolation stages.
	typedef struct packed {
		logic              valid;
		logic              neg;
		logic [AMP_W-1:0]  lo;
		logic [DIFF_W-1:0] diff;
		logic [FRAC_W-1:0] t;
	} isfp_lkp_t;

	// sin(0..pi/2) scaled to 0x7fff.
	localparam logic [AMP_W-1:0] QUARTER_WAVE [TABLE_DEPTH] = '{
		15'h0000, 15'h00c9, 15'h0192, 15'h025b, 15'h0324, 15'h03ed, 15'h04b6, 15'h057e,
		15'h0647, 15'h0710, 15'h07d9, 15'h08a1, 15'h096a, 15'h0a32, 15'h0afb, 15'h0bc3,
		15'h0c8b, 15'h0d53, 15'h0e1b, 15'h0ee3, 15'h0fab, 15'h1072, 15'h1139, 15'h1200,
		15'h12c7, 15'h138e, 15'h1455, 15'h151b, 15'h15e1, 15'h16a7, 15'h176d, 15'h1833,
		15'h18f8, 15'h19bd, 15'h1a82, 15'h1b46, 15'h1c0b, 15'h1ccf, 15'h1d93, 15'h1e56,
		15'h1f19, 15'h1fdc, 15'h209f, 15'h2161, 15'h2223, 15'h22e4, 15'h23a6, 15'h2467,
		15'h2527, 15'h25e7, 15'h26a7, 15'h2767, 15'h2826, 15'h28e5, 15'h29a3, 15'h2a61,
		15'h2b1e, 15'h2bdb, 15'h2c98, 15'h2d54, 15'h2e10, 15'h2ecc, 15'h2f86, 15'h3041,
		15'h30fb, 15'h31b4, 15'h326d, 15'h3326, 15'h33de, 15'h3496, 15'h354d, 15'h3603,
		15'h36b9, 15'h376f, 15'h3824, 15'h38d8, 15'h398c, 15'h3a3f, 15'h3af2, 15'h3ba4,
		15'h3c56, 15'h3d07, 15'h3db7, 15'h3e67, 15'h3f16, 15'h3fc5, 15'h4073, 15'h4120,
		15'h41cd, 15'h4279, 15'h4325, 15'h43d0, 15'h447a, 15'h4523, 15'h45cc, 15'h4674,
		15'h471c, 15'h47c3, 15'h4869, 15'h490e, 15'h49b3, 15'h4a57, 15'h4afa, 15'h4b9d,
		15'h4c3f, 15'h4ce0, 15'h4d80, 15'h4e20, 15'h4ebf, 15'h4f5d, 15'h4ffa, 15'h5097,
		15'h5133, 15'h51ce, 15'h5268, 15'h5301, 15'h539a, 15'h5432, 15'h54c9, 15'h555f,
		15'h55f4, 15'h5689, 15'h571d, 15'h57b0, 15'h5842, 15'h58d3, 15'h5963, 15'h59f3,
		15'h5a81, 15'h5b0f, 15'h5b9c, 15'h5c28, 15'h5cb3, 15'h5d3d, 15'h5dc6, 15'h5e4f,
		15'h5ed6, 15'h5f5d, 15'h5fe2, 15'h6067, 15'h60eb, 15'h616e, 15'h61f0, 15'h6271,
		15'h62f1, 15'h6370, 15'h63ee, 15'h646b, 15'h64e7, 15'h6562, 15'h65dd, 15'h6656,
		15'h66ce, 15'h6745, 15'h67bc, 15'h6831, 15'h68a5, 15'h6919, 15'h698b, 15'h69fc,
		15'h6a6c, 15'h6adb, 15'h6b4a, 15'h6bb7, 15'h6c23, 15'h6c8e, 15'h6cf8, 15'h6d61,
		15'h6dc9, 15'h6e30, 15'h6e95, 15'h6efa, 15'h6f5e, 15'h6fc0, 15'h7022, 15'h7082,
		15'h70e1, 15'h7140, 15'h719d, 15'h71f9, 15'h7254, 15'h72ae, 15'h7306, 15'h735e,
		15'h73b5, 15'h740a, 15'h745e, 15'h74b1, 15'h7503, 15'h7554, 15'h75a4, 15'h75f3,
		15'h7640, 15'h768d, 15'h76d8, 15'h7722, 15'h776b, 15'h77b3, 15'h77f9, 15'h783f,
		15'h7883, 15'h78c6, 15'h7908, 15'h7949, 15'h7989, 15'h79c7, 15'h7a04, 15'h7a41,
		15'h7a7c, 15'h7ab5, 15'h7aee, 15'h7b25, 15'h7b5c, 15'h7b91, 15'h7bc4, 15'h7bf7,
		15'h7c29, 15'h7c59, 15'h7c88, 15'h7cb6, 15'h7ce2, 15'h7d0e, 15'h7d38, 15'h7d61,
		15'h7d89, 15'h7db0, 15'h7dd5, 15'h7df9, 15'h7e1c, 15'h7e3e, 15'h7e5e, 15'h7e7e,
		15'h7e9c, 15'h7eb9, 15'h7ed4, 15'h7eef, 15'h7f08, 15'h7f20, 15'h7f37, 15'h7f4c,
		15'h7f61, 15'h7f74, 15'h7f86, 15'h7f96, 15'h7fa6, 15'h7fb4, 15'h7fc1, 15'h7fcd,
		15'h7fd7, 15'h7fe0, 15'h7fe8, 15'h7fef, 15'h7ff5, 15'h7ff9, 15'h7ffc, 15'h7ffe,
		15'h7fff
	};

endpackage

// ===== src/interpolated_sine_from_phase_core.sv =====
// A phase taken at a clock edge passes the stage 1, 2, 3 and 4 registers and gives its sample, with done high.
// Throughput: one phase per cycle; busy is always low since the four stages never stall.
// Rate is set by the single multiplier in stage 3, which accepts a new product every cycle.
// Reset clears the stage valid bits only; results in flight at reset are dropped.
// Depends on isfp_pkg, isfp_lookup and isfp_interp.
module interpolated_sine_from_phase_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [isfp_pkg::PHASE_W-1:0]         phase,
	output logic                                 done,
	output logic signed [isfp_pkg::SAMPLE_W-1:0] sample
);

	isfp_pkg::isfp_lkp_t lkp;
	logic                accept;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	isfp_lookup u_lookup (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept),
		.phase    (phase),
		.lkp      (lkp)
	);

	isfp_interp u_interp (
		.clk    (clk),
		.arst_n (arst_n),
		.lkp    (lkp),
		.done   (done),
		.sample (sample)
	);

	// Every transaction produces exactly one result.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##4 done)
		else $error("result missing four cycles after a transaction");

	// Sign of the sample follows the top phase bit.
	a_sign: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##4 (sample[isfp_pkg::SAMPLE_W-1] == $past(phase[isfp_pkg::PHASE_W-1], 4)))
		else $error("sample sign does not match phase half");

	// Zero phase gives a zero sample.
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (phase == '0)) |-> ##4 (sample == '0))
		else $error("zero phase did not give zero sample");

	// The lookup stage cannot show a valid item unless a transaction passed through the stage 1 valid register.
	a_lkp_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(lkp.valid && $past(arst_n, 2)) |-> $past(accept, 2))
		else $error("lookup stage valid without a transaction");

endmodule

// ===== src/isfp_lookup.sv =====
// Phase decode (stage 1) and quarter-wave table read (stage 2).
// Depends on isfp_pkg for widths, the table and the lookup struct.
module isfp_lookup (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic [isfp_pkg::PHASE_W-1:0] phase,
	output isfp_pkg::isfp_lkp_t          lkp
);

	logic                        valid_s1;
	logic                        neg_s1;
	logic [isfp_pkg::IDX_W-1:0]  i_s1;
	logic [isfp_pkg::FRAC_W-1:0] t_s1;

	logic                        valid_s2;
	logic                        neg_s2;
	logic [isfp_pkg::AMP_W-1:0]  lo_s2;
	logic [isfp_pkg::DIFF_W-1:0] diff_s2;
	logic [isfp_pkg::FRAC_W-1:0] t_s2;

	logic [1:0]                    quad;
	logic [isfp_pkg::IDX_W-1:0]    idx;
	logic [isfp_pkg::FRAC_W-1:0]   frac;
	logic [isfp_pkg::TAB_IX_W-1:0] lo_ix;
	logic [isfp_pkg::TAB_IX_W-1:0] hi_ix;
	logic [isfp_pkg::AMP_W-1:0]    lo_val;
	logic [isfp_pkg::AMP_W-1:0]    hi_val;
	logic [isfp_pkg::AMP_W-1:0]    diff_full;

	assign quad = phase[isfp_pkg::PHASE_W-1 -: 2];
	assign idx  = phase[isfp_pkg::FRAC_W +: isfp_pkg::IDX_W];
	assign frac = phase[isfp_pkg::FRAC_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	// Odd quadrants run the table backward, so the index and fraction are mirrored.
	always_ff @(posedge clk) begin
		neg_s1 <= quad[1];
		if (quad[0]) begin
			i_s1 <= isfp_pkg::IDX_MAX - idx;
			t_s1 <= isfp_pkg::FRAC_MAX - frac;
		end else begin
			i_s1 <= idx;
			t_s1 <= frac;
		end
	end

	assign lo_ix     = {1'b0, i_s1};
	assign hi_ix     = lo_ix + isfp_pkg::TAB_IX_W'(1);
	assign lo_val    = isfp_pkg::QUARTER_WAVE[lo_ix];
	assign hi_val    = isfp_pkg::QUARTER_WAVE[hi_ix];
	assign diff_full = hi_val - lo_val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	// Neighboring entries never differ by more than 0xc9, so eight bits hold the step.
	always_ff @(posedge clk) begin
		neg_s2  <= neg_s1;
		lo_s2   <= lo_val;
		diff_s2 <= diff_full[isfp_pkg::DIFF_W-1:0];
		t_s2    <= t_s1;
	end

	assign lkp.valid = valid_s2;
	assign lkp.neg   = neg_s2;
	assign lkp.lo    = lo_s2;
	assign lkp.diff  = diff_s2;
	assign lkp.t     = t_s2;

endmodule

// ===== src/isfp_interp.sv =====
// Interpolation: multiply (stage 3), divide by 0x3fffff, add and sign (stage 4).
// Depends on isfp_pkg for widths and the lookup struct.
module isfp_interp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  isfp_pkg::isfp_lkp_t                  lkp,
	output logic                                 done,
	output logic signed [isfp_pkg::SAMPLE_W-1:0] sample
);

	logic                        valid_s3;
	logic                        neg_s3;
	logic [isfp_pkg::AMP_W-1:0]  lo_s3;
	logic [isfp_pkg::PROD_W-1:0] prod_s3;

	logic                          done_s4;
	logic [isfp_pkg::SAMPLE_W-1:0] sample_s4;

	logic [isfp_pkg::DIFF_W-1:0] q0;
	logic [isfp_pkg::FRAC_W:0]   rem;
	logic                        corr;
	logic [isfp_pkg::DIFF_W-1:0] quot;
	logic [isfp_pkg::AMP_W-1:0]  amp;
	logic [isfp_pkg::SAMPLE_W-1:0] amp_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= lkp.valid;
		end
	end

	always_ff @(posedge clk) begin
		neg_s3  <= lkp.neg;
		lo_s3   <= lkp.lo;
		prod_s3 <= lkp.diff * lkp.t;
	end

	// Division by 2^22-1: the high part is the estimate, and the remainder
	// (low part plus estimate) stays below twice the divisor, so one
	// compare corrects it.
	assign q0   = prod_s3[isfp_pkg::PROD_W-1 -: isfp_pkg::DIFF_W];
	assign rem  = {1'b0, prod_s3[isfp_pkg::FRAC_W-1:0]}
	            + {{(isfp_pkg::FRAC_W+1-isfp_pkg::DIFF_W){1'b0}}, q0};
	assign corr = rem >= {1'b0, isfp_pkg::FRAC_MAX};
	assign quot = q0 + {{(isfp_pkg::DIFF_W-1){1'b0}}, corr};
	assign amp  = lo_s3 + {{(isfp_pkg::AMP_W-isfp_pkg::DIFF_W){1'b0}}, quot};
	assign amp_ext = {1'b0, amp};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s4 <= 1'b0;
		end else begin
			done_s4 <= valid_s3;
		end
	end

	// The negative half gives -1 - v, which is the bitwise inverse.
	always_ff @(posedge clk) begin
		sample_s4 <= neg_s3 ? ~amp_ext : amp_ext;
	end

	assign done   = done_s4;
	assign sample = sample_s4;

endmodule

// ===== test/isfp_sample_checker.sv =====
// Checker for the phase-to-sine core: predicts each sample from the accepted phase and compares.
// Depends on isfp_pkg for widths and the quarter-wave table; instantiated by the testbench top.
module isfp_sample_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic                                 busy,
	input  logic [isfp_pkg::PHASE_W-1:0]         phase,
	input  logic                                 done,
	input  logic signed [isfp_pkg::SAMPLE_W-1:0] sample,
	output int                                   errors,
	output int                                   outstanding
);

	typedef struct {
		logic [isfp_pkg::PHASE_W-1:0]         phase;
		logic signed [isfp_pkg::SAMPLE_W-1:0] sample;
	} sine_expect_t;

	sine_expect_t expected_samples[$];

	// Odd quadrants read the table mirrored, and the two negative quadrants are one's complemented.
	function automatic logic signed [isfp_pkg::SAMPLE_W-1:0] sine_of_phase(
		input logic [isfp_pkg::PHASE_W-1:0] ph);
		logic [1:0]                  quad;
		logic [isfp_pkg::IDX_W-1:0]  ix;
		logic [isfp_pkg::FRAC_W-1:0] t;
		logic [63:0]                 lo, hi, v;
		quad = ph[isfp_pkg::PHASE_W-1 -: 2];
		ix = ph[isfp_pkg::FRAC_W +: isfp_pkg::IDX_W];
		t = ph[isfp_pkg::FRAC_W-1:0];
		if (quad[0]) begin
			ix = isfp_pkg::IDX_MAX - ix;
			t = isfp_pkg::FRAC_MAX - t;
		end
		lo = 64'(isfp_pkg::QUARTER_WAVE[ix]);
		hi = 64'(isfp_pkg::QUARTER_WAVE[int'(ix) + 1]);
		v = lo + ((hi - lo) * 64'(t)) / 64'(isfp_pkg::FRAC_MAX);
		if (quad[1])
			v = 64'hffff - v;
		return v[isfp_pkg::SAMPLE_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sine_expect_t e;
		if (!arst_n) begin
			expected_samples.delete();
			errors = 0;
			outstanding = 0;
		end else begin
			if (start && !busy)
				expected_samples.push_back('{phase, sine_of_phase(phase)});
			if (done) begin
				if (expected_samples.size() == 0) begin
					$display("%0t unexpected sample: expected none, got %0d", $time, sample);
					errors++;
				end else begin
					e = expected_samples.pop_front();
					if (sample !== e.sample) begin
						$display("%0t sample mismatch for phase %h: expected %0d, got %0d",
							$time, e.phase, e.sample, sample);
						errors++;
					end
				end
			end
			outstanding = expected_samples.size();
		end
	end

endmodule

// ===== test/tb_interpolated_sine_from_phase_core.sv =====
// Testbench top for interpolated_sine_from_phase_core: clock, reset, phase stimulus and verdict.
// Depends on isfp_pkg, the core and isfp_sample_checker, which does all prediction and checking.
module tb_interpolated_sine_from_phase_core;

	localparam int RANDOM_PHASES = 1500;
	localparam int IDLE_LIMIT    = 500;

	logic                                 clk;
	logic                                 arst_n;
	logic                                 start;
	logic                                 busy;
	logic [isfp_pkg::PHASE_W-1:0]         phase;
	logic                                 done;
	logic signed [isfp_pkg::SAMPLE_W-1:0] sample;
	int                                   errors;
	int                                   outstanding;
	int                                   idle_cycles;

	interpolated_sine_from_phase_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.phase(phase), .done(done), .sample(sample)
	);

	isfp_sample_checker checker_i (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .phase(phase),
		.done(done), .sample(sample), .errors(errors), .outstanding(outstanding)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Ends the run when neither side has moved a transaction for too long.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("[interpolated_sine_from_phase_core] ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Holds start high until the core takes the phase; start stays high for the next call.
	task automatic send_phase(input logic [isfp_pkg::PHASE_W-1:0] ph);
		start <= 1'b1;
		phase <= ph;
		do @(posedge clk); while (busy);
	endtask

	task automatic pause_sender(input int cycles);
		if (cycles > 0) begin
			start <= 1'b0;
			phase <= $urandom;
			repeat (cycles) @(posedge clk);
		end
	endtask

	function automatic logic [isfp_pkg::PHASE_W-1:0] random_phase();
		logic [isfp_pkg::PHASE_W-1:0] ph;
		int                           kind;
		ph = $urandom;
		kind = $urandom_range(0, 9);
		case (kind)
			0: ph[isfp_pkg::FRAC_W-1:0] = '0;
			1: ph[isfp_pkg::FRAC_W-1:0] = isfp_pkg::FRAC_MAX;
			2: ph[isfp_pkg::FRAC_W-1:0] = isfp_pkg::FRAC_W'($urandom_range(0, 3));
			3: ph[isfp_pkg::FRAC_W-1:0] =
				isfp_pkg::FRAC_MAX - isfp_pkg::FRAC_W'($urandom_range(0, 3));
			4: ph[isfp_pkg::FRAC_W +: isfp_pkg::IDX_W] =
				$urandom_range(0, 1) ? isfp_pkg::IDX_MAX : '0;
			5: begin
				ph[isfp_pkg::FRAC_W +: isfp_pkg::IDX_W] =
					$urandom_range(0, 1) ? isfp_pkg::IDX_MAX : '0;
				ph[isfp_pkg::FRAC_W-1:0] = $urandom_range(0, 1) ? isfp_pkg::FRAC_MAX : '0;
			end
			default: ;
		endcase
		return ph;
	endfunction

	initial begin
		logic [isfp_pkg::PHASE_W-1:0] directed[$];
		int                           sent;
		int                           burst;
		directed = '{
			32'h0000_0000, 32'h4000_0000, 32'h3fff_ffff, 32'h8000_0000,
			32'hc000_0000, 32'hbfff_ffff, 32'hffff_ffff, 32'h7fff_ffff,
			32'h003f_ffff, 32'h0040_0000, 32'h3fc0_0000, 32'h4000_0001,
			32'h8000_0001, 32'hc03f_ffff, 32'h5555_5555, 32'haaaa_aaaa,
			32'h2000_0000, 32'h6000_0000, 32'ha000_0000, 32'he000_0000
		};
		arst_n = 1'b0;
		start = 1'b0;
		phase = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[k]) begin
			send_phase(directed[k]);
			if ($urandom_range(0, 3) == 0)
				pause_sender($urandom_range(1, 3));
		end

		sent = 0;
		while (sent < RANDOM_PHASES) begin
			burst = $urandom_range(1, 40);
			for (int k = 0; k < burst && sent < RANDOM_PHASES; k++) begin
				send_phase(random_phase());
				sent++;
			end
			// Back-to-back bursts now and then, so long stretches run without a gap.
			if ($urandom_range(0, 3) != 0)
				pause_sender($urandom_range(1, 8));
		end
		start <= 1'b0;

		while (outstanding != 0) @(negedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("[interpolated_sine_from_phase_core] OK");
		else
			$display("[interpolated_sine_from_phase_core] ERROR");
		$finish;
	end

endmodule
